// ===== rtl/psu_pkg.sv =====
// Shared types and constants for the PNG scanline unfilter.
`timescale 1ns / 1ps

package psu_pkg;

  localparam int unsigned DEF_MAX_ROW_BYTES   = 8192;
  localparam int unsigned DEF_MAX_PIXEL_BYTES = 8;

  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned BPP_W      = 4;

  // Register indexes on the configuration channel
  localparam logic CFG_BPP     = 1'b0;
  localparam logic CFG_ROW_LEN = 1'b1;

  localparam logic [BPP_W-1:0]      BPP_RESET     = 4'd4;
  localparam logic [CFG_DATA_W-1:0] ROW_LEN_RESET = 14'd1024;

  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4
  } filt_e;

  // One stream item after row bookkeeping, as held in the input register
  typedef struct packed {
    logic       is_data;    // 0: filter byte, no result
    logic [7:0] data_byte;
    logic       left_ok;    // position >= bytes per pixel
    logic       first_row;  // above row reads as zero
    filt_e      filt;
    logic       row_last;
  } item_t;

endpackage

// ===== rtl/psu_line_mem.sv =====
// Line store holding the previous reconstructed row.
`timescale 1ns / 1ps

module psu_line_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/psu_row_ctrl.sv =====
// Input register, configuration registers and row/column bookkeeping.
`timescale 1ns / 1ps

module psu_row_ctrl #(
  parameter int unsigned MAX_ROW_BYTES   = 8192,
  parameter int unsigned MAX_PIXEL_BYTES = 8,
  parameter int unsigned PW              = 13,
  parameter int unsigned SW              = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [psu_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // incoming stream
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         in_byte_i,
  input  logic                               in_start_i,
  // line store read, issued on the accept of a data byte
  output logic                               rd_en_o,
  output logic [PW-1:0]                      rd_addr_o,
  // input register toward reconstruction
  output logic                               item_valid_o,
  output psu_pkg::item_t                     item_o,
  output logic [PW-1:0]                      item_pos_o,
  output logic [SW-1:0]                      item_slot_o,
  input  logic                               item_adv_i
);

  import psu_pkg::*;

  localparam int unsigned CW = (PW + 1 > CFG_DATA_W) ? PW + 1 : CFG_DATA_W;

  logic [BPP_W-1:0]      bpp_q;
  logic [CFG_DATA_W-1:0] row_len_q;
  logic                  filt_exp_q, filt_exp_d;
  logic                  first_row_q, first_row_d;
  filt_e                 row_filt_q, row_filt_d;
  logic [PW-1:0]         pos_q, pos_d;
  // cnt_q[k] tracks position mod (k+1), so any bytes-per-pixel value has its slot ready
  logic [SW-1:0]         cnt_q [MAX_PIXEL_BYTES];
  logic [SW-1:0]         cnt_d [MAX_PIXEL_BYTES];

  logic                  item_valid_q;
  item_t                 item_q, item_d;
  logic [PW-1:0]         item_pos_q;
  logic [SW-1:0]         item_slot_q, slot_c;

  logic [BPP_W-1:0]      bpp_c;
  logic [CW-1:0]         row_len_c;
  logic                  accept, is_filt, last_c;

  assign in_ready_o = !item_valid_q || item_adv_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_filt    = in_start_i || filt_exp_q;

  always_comb begin
    bpp_c = bpp_q;
    if (bpp_q == '0) begin
      bpp_c = BPP_W'(1);
    end else if (32'(bpp_q) > MAX_PIXEL_BYTES) begin
      bpp_c = BPP_W'(MAX_PIXEL_BYTES);
    end
    row_len_c = CW'(row_len_q);
    if (row_len_q == '0) begin
      row_len_c = CW'(1);
    end else if (32'(row_len_q) > MAX_ROW_BYTES) begin
      row_len_c = CW'(MAX_ROW_BYTES);
    end
  end

  assign slot_c = cnt_q[SW'(bpp_c - BPP_W'(1))];
  assign last_c = (CW'(pos_q) + CW'(1)) >= row_len_c;

  always_comb begin
    filt_exp_d  = filt_exp_q;
    first_row_d = first_row_q;
    row_filt_d  = row_filt_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;

    item_d.is_data   = !is_filt;
    item_d.data_byte = in_byte_i;
    item_d.left_ok   = CW'(pos_q) >= CW'(bpp_c);
    item_d.first_row = first_row_q;
    item_d.filt      = row_filt_q;
    item_d.row_last  = last_c;

    if (is_filt) begin
      filt_exp_d = 1'b0;
      pos_d      = '0;
      row_filt_d = (in_byte_i > 8'(FLT_PAETH)) ? FLT_NONE : filt_e'(in_byte_i[2:0]);
      for (int k = 0; k < int'(MAX_PIXEL_BYTES); k++) begin
        cnt_d[k] = '0;
      end
      if (in_start_i) begin
        first_row_d = 1'b1;
      end
    end else if (last_c) begin
      filt_exp_d  = 1'b1;
      first_row_d = 1'b0;
      pos_d       = '0;
    end else begin
      pos_d = pos_q + PW'(1);
      for (int k = 0; k < int'(MAX_PIXEL_BYTES); k++) begin
        cnt_d[k] = (cnt_q[k] == SW'(k)) ? '0 : cnt_q[k] + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q        <= BPP_RESET;
      row_len_q    <= ROW_LEN_RESET;
      filt_exp_q   <= 1'b1;
      first_row_q  <= 1'b1;
      row_filt_q   <= FLT_NONE;
      pos_q        <= '0;
      item_valid_q <= 1'b0;
      for (int k = 0; k < int'(MAX_PIXEL_BYTES); k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_BPP:     bpp_q     <= cfg_data_i[BPP_W-1:0];
          CFG_ROW_LEN: row_len_q <= cfg_data_i;
          default:     ;
        endcase
      end
      if (accept) begin
        filt_exp_q  <= filt_exp_d;
        first_row_q <= first_row_d;
        row_filt_q  <= row_filt_d;
        pos_q       <= pos_d;
        cnt_q       <= cnt_d;
      end
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q      <= item_d;
      item_pos_q  <= pos_q;
      item_slot_q <= slot_c;
    end
  end

  assign rd_en_o      = accept && !is_filt;
  assign rd_addr_o    = pos_q;
  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;
  assign item_pos_o   = item_pos_q;
  assign item_slot_o  = item_slot_q;

endmodule

// ===== rtl/psu_recon.sv =====
// Filter reconstruction from the input register into the result register.
`timescale 1ns / 1ps

module psu_recon #(
  parameter int unsigned MAX_PIXEL_BYTES = 8,
  parameter int unsigned PW              = 13,
  parameter int unsigned SW              = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  psu_pkg::item_t        item_i,
  input  logic [PW-1:0]         item_pos_i,
  input  logic [SW-1:0]         item_slot_i,
  output logic                  item_adv_o,
  input  logic [7:0]            above_i,
  // line store write
  output logic                  wr_en_o,
  output logic [PW-1:0]         wr_addr_o,
  output logic [7:0]            wr_data_o,
  // result stream
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o
);

  import psu_pkg::*;

  logic [7:0] left_q [MAX_PIXEL_BYTES];
  logic [7:0] upleft_q [MAX_PIXEL_BYTES];

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic [7:0] a, b, c, pred, result;
  logic [8:0] avg_sum;
  logic signed [9:0] d_pa, d_pb, d_pc;
  logic [9:0] pa, pb, pc;
  logic       data_adv;

  // a filter byte passes as a bubble, a data byte needs room in the result register
  assign item_adv_o = item_valid_i && (!item_i.is_data || !out_valid_q || out_ready_i);
  assign data_adv   = item_adv_o && item_i.is_data;

  always_comb begin
    a = item_i.left_ok ? left_q[item_slot_i] : 8'd0;
    b = item_i.first_row ? 8'd0 : above_i;
    c = (item_i.left_ok && !item_i.first_row) ? upleft_q[item_slot_i] : 8'd0;

    avg_sum = {1'b0, a} + {1'b0, b};

    // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    d_pa = $signed({2'b00, b}) - $signed({2'b00, c});
    d_pb = $signed({2'b00, a}) - $signed({2'b00, c});
    d_pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa   = d_pa[9] ? 10'(-d_pa) : 10'(d_pa);
    pb   = d_pb[9] ? 10'(-d_pb) : 10'(d_pb);
    pc   = d_pc[9] ? 10'(-d_pc) : 10'(d_pc);

    case (item_i.filt)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = avg_sum[8:1];
      FLT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:   pred = 8'd0;
    endcase

    result = item_i.data_byte + pred;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < int'(MAX_PIXEL_BYTES); k++) begin
        left_q[k]   <= 8'd0;
        upleft_q[k] <= 8'd0;
      end
    end else begin
      if (data_adv) begin
        out_valid_q            <= 1'b1;
        left_q[item_slot_i]    <= result;
        upleft_q[item_slot_i]  <= b;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_adv) begin
      out_byte_q <= result;
      out_last_q <= item_i.row_last;
    end
  end

  assign wr_en_o     = data_adv;
  assign wr_addr_o   = item_pos_i;
  assign wr_data_o   = result;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/png_scanline_unfilter.sv =====
// Top level of the PNG scanline unfilter.
//
// Input stream (s_axis): one byte of the inflated image per transfer, tuser
// marks the first byte of a new image. The first byte of each row is the
// filter type and yields no output; every later byte yields one reconstructed
// byte on m_axis, with tlast on the last byte of the row.
// Configuration: cfg_valid_i/cfg_ready_o with index 0 = bytes per pixel and
// index 1 = data bytes per row; write only while no byte is in flight.
// The byte is loaded into the input register at the transfer (line store read
// issued at the same edge) and from there into the result register, which
// drives m_axis_tvalid; a stalled receiver can hold it in the input register.
// Throughput is one byte per cycle, filter bytes included, while the receiver
// does not stall; the row store has one read and one write port, and the
// reconstruction adder/Paeth logic sees the row read in the cycle after accept.
// Reset brings back 4 bytes per pixel, 1024 bytes per row, and the first row
// of an image (above row reads as zero); no clearing pass is needed.
// When the receiver stalls, the result register holds and the input register
// fills, after which s_axis_tready drops until the output moves.
`timescale 1ns / 1ps

module png_scanline_unfilter #(
  parameter int unsigned MAX_ROW_BYTES   = psu_pkg::DEF_MAX_ROW_BYTES,
  parameter int unsigned MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
  input  logic                           s_axis_tuser,   // [0] frame_start
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] pixel_byte
  output logic                           m_axis_tlast    // row_last
);

  import psu_pkg::*;

  localparam int unsigned PW = $clog2(MAX_ROW_BYTES);
  localparam int unsigned SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic          rd_en, wr_en, item_valid, item_adv;
  logic [PW-1:0] rd_addr, wr_addr, item_pos;
  logic [7:0]    rd_data, wr_data;
  item_t         item;
  logic [SW-1:0] item_slot;

  assign cfg_ready_o = 1'b1;

  psu_row_ctrl #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
    .PW             (PW),
    .SW             (SW)
  ) u_row_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_pos_o  (item_pos),
    .item_slot_o (item_slot),
    .item_adv_i  (item_adv)
  );

  psu_line_mem #(
    .DEPTH(MAX_ROW_BYTES),
    .AW   (PW)
  ) u_line_mem (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  psu_recon #(
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
    .PW             (PW),
    .SW             (SW)
  ) u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pos_i  (item_pos),
    .item_slot_i (item_slot),
    .item_adv_o  (item_adv),
    .above_i     (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== bench/png_scanline_unfilter_tb.sv =====
// Self-checking stream testbench for the PNG scanline unfilter.
`timescale 1ns / 1ps

module png_scanline_unfilter_tb;
  import psu_pkg::*;

  localparam int unsigned ROW_MAX          = DEF_MAX_ROW_BYTES;
  localparam int unsigned PIX_MAX          = DEF_MAX_PIXEL_BYTES;
  localparam int unsigned DRAIN_CYCLES     = 6;
  localparam int unsigned SINK_HOLD_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS     = 320;
  localparam logic [7:0]  FILT_BYTE_BAD    = 8'hFF;

  typedef struct packed {
    logic [7:0] data;
    logic       fstart;
  } feed_item_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
  } pix_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i = CFG_BPP;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tuser  = 1'b0;

  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  png_scanline_unfilter dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus and expected pixels
  feed_item_t byte_feed[$];
  pix_rec_t   pixels_due[$];

  int unsigned feed_total  = 0;
  int unsigned s_offered   = 0;
  int unsigned s_accepts   = 0;
  int unsigned out_xfers   = 0;
  int unsigned out_seen    = 0;
  int unsigned errors      = 0;
  int unsigned reg_writes  = 0;
  int unsigned settings    = 0;
  int unsigned stall_req   = 0;
  int unsigned stall_done  = 0;
  int unsigned feed_gap    = 0;
  int unsigned sink_wait   = 0;
  int unsigned sink_hold   = 0;
  bit          burst_mode  = 1'b0;

  // predictor state
  logic [BPP_W-1:0]      bpp_cfg     = BPP_RESET;
  logic [CFG_DATA_W-1:0] row_len_cfg = ROW_LEN_RESET;
  logic [7:0]            line_store[ROW_MAX];
  logic [7:0]            left_hist[PIX_MAX]   = '{default: 8'h00};
  logic [7:0]            upleft_hist[PIX_MAX] = '{default: 8'h00};
  filt_e                 row_filt = FLT_NONE;
  int unsigned           col      = 0;
  bit                    top_row  = 1'b1;

  function automatic int unsigned eff_row_len();
    if (row_len_cfg == 0) return 1;
    if (row_len_cfg > ROW_MAX) return ROW_MAX;
    return row_len_cfg;
  endfunction

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int pa, pb, pc;
    pa = (b > c) ? int'(b) - int'(c) : int'(c) - int'(b);
    pb = (a > c) ? int'(a) - int'(c) : int'(c) - int'(a);
    pc = int'(a) + int'(b) - 2 * int'(c);
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // One accepted stream byte: updates the row state, queues a pixel for data bytes
  function automatic void unfilter_byte(input logic [7:0] din, input logic fstart);
    int unsigned bpp, len, pos, slot;
    logic [7:0]  a, b, c, pred, pix;
    if (fstart) begin
      col = 0;
      top_row = 1'b1;
    end
    if (col == 0) begin
      row_filt = (din > 8'(FLT_PAETH)) ? FLT_NONE : filt_e'(din[2:0]);
      col = 1;
      return;
    end
    bpp = (bpp_cfg == 0) ? 1 : (bpp_cfg > PIX_MAX) ? PIX_MAX : bpp_cfg;
    len = eff_row_len();
    pos = col - 1;
    if (pos >= ROW_MAX) pos = ROW_MAX - 1;
    slot = pos % bpp;
    b = top_row ? 8'h00 : line_store[pos];
    a = (pos >= bpp) ? left_hist[slot] : 8'h00;
    c = (pos >= bpp && !top_row) ? upleft_hist[slot] : 8'h00;
    case (row_filt)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = 8'((int'(a) + int'(b)) >> 1);
      FLT_PAETH: pred = paeth_pick(a, b, c);
      default:   pred = 8'h00;
    endcase
    pix = din + pred;
    upleft_hist[slot] = b;
    left_hist[slot]   = pix;
    line_store[pos]   = pix;
    pixels_due.push_back('{pixel: pix, row_end: (pos + 1 >= len)});
    if (pos + 1 >= len) begin
      col = 0;
      top_row = 1'b0;
    end else begin
      col = pos + 2;
    end
  endfunction

  function automatic int unsigned draw_wait();
    return burst_mode ? 0 : $urandom_range(0, 10);
  endfunction

  // sampling, prediction and checking at the rising edge
  always @(posedge clk_i) begin
    pix_rec_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        s_accepts++;
        unfilter_byte(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_xfers++;
        if (pixels_due.size() == 0) begin
          $error("output transfer with no pixel expected: pixel_byte=%02h row_last=%0b",
                 m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = pixels_due.pop_front();
          if (m_axis_tdata !== want.pixel) begin
            $error("pixel_byte: expected %02h, got %02h", want.pixel, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== want.row_end) begin
            $error("row_last: expected %0b, got %0b", want.row_end, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  // byte driver
  always @(negedge clk_i) begin
    feed_item_t nxt;
    logic       drive_v;
    drive_v = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_accepts == s_offered) drive_v = 1'b0;
      if (!drive_v) begin
        if (feed_gap > 0) begin
          feed_gap--;
        end else if (byte_feed.size() != 0) begin
          nxt = byte_feed.pop_front();
          s_axis_tdata <= nxt.data;
          s_axis_tuser <= nxt.fstart;
          s_offered++;
          drive_v = 1'b1;
          feed_gap = draw_wait();
        end
      end
    end
    s_axis_tvalid <= drive_v;
  end

  // pixel sink; a stall request holds tready low for a long stretch
  always @(negedge clk_i) begin
    logic rdy;
    if (out_xfers != out_seen) begin
      out_seen = out_xfers;
      sink_wait = draw_wait();
    end
    if (stall_req != stall_done) begin
      stall_done++;
      sink_hold = SINK_HOLD_CYCLES;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      rdy = 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    m_axis_tready <= rdy;
  end

  task automatic push_item(input logic [7:0] data, input logic fstart);
    byte_feed.push_back('{data: data, fstart: fstart});
    feed_total++;
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_filter();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(5, 255));
    return 8'($urandom_range(0, 4));
  endfunction

  // a frame of whole rows; sometimes a row is cut short by the next frame start
  task automatic queue_frame(input int unsigned rows, input bit allow_cut);
    int unsigned len, n;
    len = eff_row_len();
    for (int unsigned r = 0; r < rows; r++) begin
      push_item(rand_filter(), r == 0);
      n = len;
      if (allow_cut && $urandom_range(0, 9) == 0) n = $urandom_range(0, len - 1);
      for (int unsigned i = 0; i < n; i++) push_item(rand_data(), 1'b0);
      if (n < len) return;
    end
  endtask

  task automatic queue_partial(input int unsigned n);
    push_item(rand_filter(), 1'b1);
    for (int unsigned i = 0; i < n; i++) push_item(rand_data(), 1'b0);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_BPP) bpp_cfg = val[BPP_W-1:0];
    else row_len_cfg = val;
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(input int unsigned bpp, input int unsigned len);
    write_reg(CFG_BPP, CFG_DATA_W'(bpp));
    write_reg(CFG_ROW_LEN, CFG_DATA_W'(len));
    settings++;
  endtask

  // all bytes taken, all pixels out, and the pipe drained of trailing filter bytes
  task automatic wait_idle();
    while (byte_feed.size() != 0 || s_axis_tvalid || pixels_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned bpp_tab[8] = '{1, 8, 0, 15, 3, 2, 9, 6};
    int unsigned len_tab[8] = '{1, 16, 0, 7, 5, 9, 3, 13};
    int unsigned ph, bpp, len, frames, rows, goal;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: start of a long row only
    queue_partial(12);
    wait_idle();

    // directed: each filter, the unknown type, both borders, extremes, mid-row frame start
    apply_setting(2, 3);
    push_item(8'(FLT_NONE), 1'b1);
    push_item(8'h00, 1'b0); push_item(8'hFF, 1'b0); push_item(8'h80, 1'b0);
    push_item(8'(FLT_SUB), 1'b0);
    push_item(8'hFF, 1'b0); push_item(8'h01, 1'b0); push_item(8'hFF, 1'b0);
    push_item(8'(FLT_UP), 1'b0);
    push_item(8'h00, 1'b0); push_item(8'hFF, 1'b0); push_item(8'h7F, 1'b0);
    push_item(8'(FLT_AVG), 1'b0);
    push_item(8'h01, 1'b0); push_item(8'hFF, 1'b0); push_item(8'h00, 1'b0);
    push_item(FILT_BYTE_BAD, 1'b0);
    push_item(8'h12, 1'b0);
    push_item(8'(FLT_PAETH), 1'b1);
    push_item(8'h80, 1'b0); push_item(8'h7F, 1'b0); push_item(8'hFF, 1'b0);
    push_item(8'(FLT_PAETH), 1'b0);
    push_item(8'hFF, 1'b0); push_item(8'h00, 1'b0); push_item(8'h81, 1'b0);
    wait_idle();

    // random phases over a range of settings
    goal = feed_total + RANDOM_ITEMS;
    ph = 0;
    while (feed_total < goal) begin
      if (ph < 8) begin
        bpp = bpp_tab[ph];
        len = len_tab[ph];
      end else begin
        bpp = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        len = $urandom_range(1, 24);
      end
      apply_setting(bpp, len);
      burst_mode = (ph % 3 == 2);
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        rows = 2 + 48 / ((eff_row_len() + 1) * frames);
        queue_frame(rows, 1'b1);
      end
      if (ph == 2 || ph == 8) stall_req++;
      wait_idle();
      ph++;
    end

    // longest rows: row length above the maximum, a burst of bytes at full rate
    burst_mode = 1'b1;
    apply_setting(5, 16383);
    queue_partial(24);
    wait_idle();
    burst_mode = 1'b0;
    apply_setting(7, ROW_MAX);
    queue_partial(14);
    wait_idle();

    if (pixels_due.size() != 0) begin
      $error("%0d expected pixels never arrived", pixels_due.size());
      errors++;
    end
    $display("run covered %0d byte transfers and %0d pixel transfers", s_accepts, out_xfers);
    $display("across %0d register settings (%0d register writes), %0d mismatches",
             settings, reg_writes, errors);
    if (errors == 0) begin
      $display("png_scanline_unfilter_tb: PASS");
    end else begin
      $display("png_scanline_unfilter_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d bytes left to send, %0d pixels outstanding",
             byte_feed.size(), pixels_due.size());
    $display("png_scanline_unfilter_tb: FAIL");
    $finish;
  end

endmodule
